### hw/rtl/abs_vertical_diff_row_sums_macros.svh
// Assertion macros shared by the row-sum checker.
`ifndef ABS_VERTICAL_DIFF_ROW_SUMS_MACROS_SVH
`define ABS_VERTICAL_DIFF_ROW_SUMS_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define AVDRS_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define AVDRS_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also holds through reset.
`define AVDRS_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/avdrs_pkg.sv
// Shared constants and types for the vertical-difference row-sum block.
package avdrs_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int PIX_W         = 8;
  localparam int SUM_W         = 20;
  localparam int IW_W          = 13;
  localparam int IH_W          = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 24;
  localparam int OQ_DEPTH      = 8;
  localparam int OQ_PW         = $clog2(OQ_DEPTH);
  localparam int OQ_CW         = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IW_W-1:0] IMAGE_WIDTH_RST  = 13'd4096;
  localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 16'd1;

  // One result in the output queue.
  typedef struct packed {
    logic             last_row;
    logic [SUM_W-1:0] row_sum;
  } item_t;

  // Results produced by the accumulate stage in one cycle.
  typedef struct packed {
    logic             push_sum;
    logic             push_last;
    logic [SUM_W-1:0] row_sum;
  } push_t;

endpackage

### hw/rtl/avdrs_ram.sv
// Generic single-clock RAM, one write and one read port, registered read-first.
module avdrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read returns the old entry on a same-address write
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/avdrs_oq.sv
// Output queue: takes up to two results per cycle, delivers one per request.
module avdrs_oq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  avdrs_pkg::push_t           push,
  output logic [avdrs_pkg::OQ_CW-1:0] count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output avdrs_pkg::item_t           out_item
);

  avdrs_pkg::item_t                 mem_r [avdrs_pkg::OQ_DEPTH];
  logic [avdrs_pkg::OQ_PW-1:0]      head_r, head_nxt;
  logic [avdrs_pkg::OQ_PW-1:0]      tail_r, tail_nxt;
  logic [avdrs_pkg::OQ_PW-1:0]      last_slot;
  logic [avdrs_pkg::OQ_CW-1:0]      count_r, count_nxt;
  logic [avdrs_pkg::OQ_CW-1:0]      n_push;
  logic                             pop;
  avdrs_pkg::item_t                 sum_item, last_item;

  assign pop       = out_valid && out_ready;
  assign n_push    = avdrs_pkg::OQ_CW'(push.push_sum) + avdrs_pkg::OQ_CW'(push.push_last);
  assign last_slot = push.push_sum ? tail_r + 1'b1 : tail_r;

  always_comb begin
    sum_item.last_row  = 1'b0;
    sum_item.row_sum   = push.row_sum;
    last_item.last_row = 1'b1;
    last_item.row_sum  = '0;
    head_nxt  = pop ? head_r + 1'b1 : head_r;
    tail_nxt  = tail_r + avdrs_pkg::OQ_PW'(n_push);
    count_nxt = count_r + n_push - avdrs_pkg::OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_sum) begin
      mem_r[tail_r] <= sum_item;
    end
    if (push.push_last) begin
      mem_r[last_slot] <= last_item;
    end
  end

  assign count     = count_r;
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[head_r];

endmodule

### hw/rtl/abs_vertical_diff_row_sums.sv
// Top level: row sums of absolute vertical pixel differences over a stream.
// Throughput: one pixel per cycle while in_tready is high; the line RAM is read and written for each
//   pixel in the cycle it is accepted, and the sum is updated in the next cycle.
// A row's results go through the stage registers into the output queue, which drives out_tvalid.
// Reset (rst_n, synchronous, active low) clears counters, the sum, the output
//   queue and the registers (width 4096, height 1); the line RAM is not cleared.
module abs_vertical_diff_row_sums #(
  parameter int MAX_WIDTH = avdrs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [avdrs_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] pixel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [avdrs_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [19:0] row_sum, [23:20] zero
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [avdrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [avdrs_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int EW0 = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (EW0 > avdrs_pkg::IW_W) ? EW0 : avdrs_pkg::IW_W;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
  localparam int SW  = avdrs_pkg::SUM_W;
  localparam int PW  = avdrs_pkg::PIX_W;
  localparam int CW  = avdrs_pkg::OQ_CW;

  typedef struct packed {
    logic row_nz;
    logic row_end;
    logic frame_end;
  } ctl_t;

  logic [avdrs_pkg::IW_W-1:0] image_width_r, image_width_nxt;
  logic [avdrs_pkg::IH_W-1:0] image_height_r, image_height_nxt;
  logic [AW-1:0]              col_r, col_nxt;
  logic [avdrs_pkg::IH_W-1:0] row_r, row_nxt;
  logic [SW-1:0]              sum_r, sum_nxt;
  logic                       sb_v_r;
  logic [PW-1:0]              sb_px_r;
  ctl_t                       sb_ctl_r, ctl_a;

  logic [EW-1:0]              iw_ext, wlast;
  logic [avdrs_pkg::IH_W-1:0] hlast;
  logic                       accept;
  logic [PW-1:0]              pixel, prev_px, diff;
  logic [SW:0]                sum_add;
  logic [SW-1:0]              sum_upd;
  avdrs_pkg::push_t           push;
  logic [CW-1:0]              oq_count;
  logic [CW:0]                oq_need;
  avdrs_pkg::item_t           out_item;

  // register writes
  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        avdrs_pkg::REG_IMAGE_WIDTH:  image_width_nxt  = cfg_wdata[avdrs_pkg::IW_W-1:0];
        avdrs_pkg::REG_IMAGE_HEIGHT: image_height_nxt = cfg_wdata[avdrs_pkg::IH_W-1:0];
        default: ;
      endcase
    end
  end

  // last column and last row in use
  always_comb begin
    iw_ext = EW'(image_width_r);
    if (iw_ext == '0) begin
      wlast = '0;
    end else if (iw_ext > MAXW) begin
      wlast = MAXW - 1'b1;
    end else begin
      wlast = iw_ext - 1'b1;
    end
    hlast = (image_height_r == '0) ? '0 : image_height_r - 1'b1;
  end

  assign pixel  = in_tdata[PW-1:0];
  assign accept = in_tvalid && in_tready;

  always_comb begin
    ctl_a.row_nz    = (row_r != '0);
    ctl_a.row_end   = (EW'(col_r) >= wlast);
    ctl_a.frame_end = (row_r >= hlast);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (ctl_a.row_end) begin
        col_nxt = '0;
        row_nxt = ctl_a.frame_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // read the pixel above and store the new one in the same cycle
  avdrs_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (pixel),
    .re    (accept),
    .raddr (col_r),
    .rdata (prev_px)
  );

  // accumulate stage
  always_comb begin
    diff    = (sb_px_r >= prev_px) ? sb_px_r - prev_px : prev_px - sb_px_r;
    sum_add = {1'b0, sum_r} + (SW + 1)'(diff);
    if (sb_ctl_r.row_nz) begin
      sum_upd = sum_add[SW] ? '1 : sum_add[SW-1:0];
    end else begin
      sum_upd = sum_r;
    end
    sum_nxt = sum_r;
    if (sb_v_r) begin
      sum_nxt = sb_ctl_r.row_end ? '0 : sum_upd;
    end
    push.push_sum  = sb_v_r && sb_ctl_r.row_end && sb_ctl_r.row_nz;
    push.push_last = sb_v_r && sb_ctl_r.row_end && sb_ctl_r.frame_end;
    push.row_sum   = sum_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= avdrs_pkg::IMAGE_WIDTH_RST;
      image_height_r <= avdrs_pkg::IMAGE_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      sum_r          <= '0;
      sb_v_r         <= 1'b0;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      sum_r          <= sum_nxt;
      sb_v_r         <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sb_px_r  <= pixel;
      sb_ctl_r <= ctl_a;
    end
  end

  avdrs_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .count     (oq_count),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  // hold room for two results from the pixel in flight and two from a new one
  assign oq_need   = (CW + 1)'(oq_count) + (sb_v_r ? (CW + 1)'(2) : '0);
  assign in_tready = (oq_need <= (CW + 1)'(avdrs_pkg::OQ_DEPTH - 2));

  assign out_tdata = avdrs_pkg::OUT_TDATA_W'(out_item.row_sum);
  assign out_tlast = out_item.last_row;

endmodule

### hw/rtl/avdrs_checker.sv
// Port-level checks for the row-sum block, bound to the top level.
`include "abs_vertical_diff_row_sums_macros.svh"

module avdrs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [avdrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast
);

  `AVDRS_ASSERT_ALWAYS(a_idle_after_reset, clk, $rose(rst_n), !out_tvalid, "result right after reset")
  `AVDRS_ASSERT_NXT(a_hold_stalled, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `AVDRS_ASSERT_IMP(a_last_is_zero, clk, rst_n, out_tvalid && out_tlast, out_tdata == '0, "final-row result not zero")
  `AVDRS_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[avdrs_pkg::OUT_TDATA_W-1:avdrs_pkg::SUM_W] == '0, "padding bits set")

endmodule

bind abs_vertical_diff_row_sums avdrs_checker u_avdrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
